@@ rtl/binary_block_downsampler_assert.svh @@
// Assertion macros used by the downsampler queue.
`ifndef BINARY_BLOCK_DOWNSAMPLER_ASSERT_SVH
`define BINARY_BLOCK_DOWNSAMPLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bbd_pkg.sv @@
// Shared constants, types and helper functions of the binary block downsampler.
package bbd_pkg;

  localparam int GRID     = 28;
  localparam int MAX_ROWS = 512;
  localparam int MAX_COLS = 1024;

  localparam int ROWS_W  = 10;  // effective row count, up to MAX_ROWS
  localparam int COLS_W  = 11;  // effective column count, up to MAX_COLS
  localparam int RPOS_W  = 9;   // row position, below MAX_ROWS
  localparam int CPOS_W  = 10;  // column position, below MAX_COLS
  localparam int BH_W    = 5;   // block height, up to MAX_ROWS / GRID
  localparam int BW_W    = 6;   // block width, up to MAX_COLS / GRID
  localparam int IDX_W   = 5;   // block index, up to GRID
  localparam int START_W = 4;   // leading margin, below GRID / 2
  localparam int SUM_W   = 10;  // block population, up to the block area
  localparam int CELL_W  = 10;  // cell index, below GRID * GRID
  localparam int CFG_W   = 11;  // widest configuration register

  localparam int RESET_ROWS = 28;
  localparam int RESET_COLS = 28;

  // size / GRID as a multiply by a rounded-up reciprocal; exact for sizes up to MAX_COLS
  localparam int DIV_SHIFT = 16;
  localparam int DIV_RECIP = (1 << DIV_SHIFT) / GRID + 1;
  localparam int QUOT_W    = 6;
  localparam int PROD_W    = COLS_W + 12;

  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  typedef enum logic [0:0] {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [ROWS_W-1:0]  rows;
    logic [COLS_W-1:0]  cols;
    logic [BH_W-1:0]    bh;
    logic [BW_W-1:0]    bw;
    logic [START_W-1:0] ystart;
    logic [START_W-1:0] xstart;
  } geom_t;

  typedef struct packed {
    logic             pixel;
    logic [IDX_W-1:0] col_blk;
    logic [IDX_W-1:0] row_blk;
    logic             block_end;
    logic             last;
  } q_entry_t;

  typedef struct packed {
    logic [QUOT_W-1:0]  quot;
    logic [START_W-1:0] half;
  } split_t;

  // Block size and half of the leftover margin for one side.
  function automatic split_t grid_split(input logic [COLS_W-1:0] size);
    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;
    logic [COLS_W-1:0] base;
    logic [COLS_W-1:0] rem;
    split_t            res;
    prod = PROD_W'(size) * PROD_W'(DIV_RECIP);
    quot = prod[DIV_SHIFT+QUOT_W-1:DIV_SHIFT];
    base = COLS_W'(quot) * COLS_W'(GRID);
    rem  = size - base;
    res.quot = quot;
    res.half = rem[START_W:1];
    return res;
  endfunction

endpackage

@@ rtl/binary_block_downsampler.sv @@
// Top level of the binary block downsampler.
//
//  port group  | dir | contents
//  ------------+-----+----------------------------------------------------------
//  in_*        | in  | one binary pixel per transfer, row-major
//  out_*       | out | one grid cell per completed block, tlast on the final cell
//  cfg_*       | in  | register writes: 0 rows_in_use, 1 cols_in_use
//
//  One pixel per cycle while the queue is not full; a cell's last pixel passes through
//  the queue register, then the output register, before the cell leaves.
//  The four-entry queue lets pixels keep arriving while a cell waits on out_tready.
//  A register write restarts the frame on the same edge; reset restores 28 x 28.
//  Reset is synchronous, active low, and needs no clearing pass.
module binary_block_downsampler (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [0] pixel, [7:1] zero
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [15:0]               out_tdata,  // [0] cell_value, [10:1] cell_index, [15:11] zero
  output logic                      out_tlast,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [bbd_pkg::CFG_W-1:0] cfg_wdata
);

  bbd_pkg::geom_t             geom;
  logic                       restart;
  logic                       in_fire;
  logic                       push;
  bbd_pkg::q_entry_t          push_data;
  logic                       q_full;
  logic                       pop;
  logic                       head_valid;
  bbd_pkg::q_entry_t          head;
  logic                       cell_value;
  logic [bbd_pkg::CELL_W-1:0] cell_index;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  bbd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom),
    .restart   (restart)
  );

  bbd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .restart   (restart),
    .in_fire   (in_fire),
    .in_pixel  (in_tdata[0]),
    .push      (push),
    .push_data (push_data)
  );

  bbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  bbd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .geom       (geom),
    .restart    (restart),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_value  (cell_value),
    .out_index  (cell_index),
    .out_last   (out_tlast),
    .out_ready  (out_tready)
  );

  assign out_tdata = {5'b0, cell_index, cell_value};

endmodule

@@ rtl/bbd_cfg.sv @@
// Configuration registers and derived block geometry.
module bbd_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [bbd_pkg::CFG_W-1:0] cfg_wdata,
  output bbd_pkg::geom_t            geom,
  output logic                      restart
);

  bbd_pkg::geom_t                   geom_r;
  bbd_pkg::geom_t                   geom_nxt;
  bbd_pkg::geom_t                   geom_rst;
  logic [bbd_pkg::ROWS_W-1:0]       rows_eff;
  logic [bbd_pkg::COLS_W-1:0]       cols_eff;
  bbd_pkg::split_t                  row_split;
  bbd_pkg::split_t                  col_split;
  bbd_pkg::split_t                  row_split_rst;
  bbd_pkg::split_t                  col_split_rst;

  // Saturate oversized regions, treat a zero size as one.
  always_comb begin
    rows_eff = cfg_wdata[bbd_pkg::ROWS_W-1:0];
    if (cfg_wdata[bbd_pkg::ROWS_W-1:0] > bbd_pkg::ROWS_W'(bbd_pkg::MAX_ROWS)) begin
      rows_eff = bbd_pkg::ROWS_W'(bbd_pkg::MAX_ROWS);
    end else if (cfg_wdata[bbd_pkg::ROWS_W-1:0] == '0) begin
      rows_eff = bbd_pkg::ROWS_W'(1);
    end
    cols_eff = cfg_wdata;
    if (cfg_wdata > bbd_pkg::COLS_W'(bbd_pkg::MAX_COLS)) begin
      cols_eff = bbd_pkg::COLS_W'(bbd_pkg::MAX_COLS);
    end else if (cfg_wdata == '0) begin
      cols_eff = bbd_pkg::COLS_W'(1);
    end
  end

  assign row_split     = bbd_pkg::grid_split(bbd_pkg::COLS_W'(rows_eff));
  assign col_split     = bbd_pkg::grid_split(cols_eff);
  assign row_split_rst = bbd_pkg::grid_split(bbd_pkg::COLS_W'(bbd_pkg::RESET_ROWS));
  assign col_split_rst = bbd_pkg::grid_split(bbd_pkg::COLS_W'(bbd_pkg::RESET_COLS));

  always_comb begin
    geom_rst.rows   = bbd_pkg::ROWS_W'(bbd_pkg::RESET_ROWS);
    geom_rst.cols   = bbd_pkg::COLS_W'(bbd_pkg::RESET_COLS);
    geom_rst.bh     = row_split_rst.quot[bbd_pkg::BH_W-1:0];
    geom_rst.bw     = col_split_rst.quot[bbd_pkg::BW_W-1:0];
    geom_rst.ystart = row_split_rst.half;
    geom_rst.xstart = col_split_rst.half;
  end

  always_comb begin
    geom_nxt = geom_r;
    if (cfg_we) begin
      case (bbd_pkg::reg_idx_t'(cfg_index))
        bbd_pkg::REG_ROWS: begin
          geom_nxt.rows   = rows_eff;
          geom_nxt.bh     = row_split.quot[bbd_pkg::BH_W-1:0];
          geom_nxt.ystart = row_split.half;
        end
        bbd_pkg::REG_COLS: begin
          geom_nxt.cols   = cols_eff;
          geom_nxt.bw     = col_split.quot[bbd_pkg::BW_W-1:0];
          geom_nxt.xstart = col_split.half;
        end
        default: geom_nxt = geom_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r <= geom_rst;
    end else begin
      geom_r <= geom_nxt;
    end
  end

  assign geom    = geom_r;
  // Every register index in use restarts the frame.
  assign restart = cfg_we;

endmodule

@@ rtl/bbd_front.sv @@
// Front end: frame position tracking and per-pixel block classification.
module bbd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  bbd_pkg::geom_t      geom,
  input  logic                restart,
  input  logic                in_fire,
  input  logic                in_pixel,
  output logic                push,
  output bbd_pkg::q_entry_t   push_data
);

  logic [bbd_pkg::RPOS_W-1:0] row_pos_r, row_pos_nxt;
  logic [bbd_pkg::CPOS_W-1:0] col_pos_r, col_pos_nxt;
  logic [bbd_pkg::BH_W-1:0]   rib_r, rib_nxt;
  logic [bbd_pkg::BW_W-1:0]   cib_r, cib_nxt;
  logic [bbd_pkg::IDX_W-1:0]  blk_row_r, blk_row_nxt;
  logic [bbd_pkg::IDX_W-1:0]  blk_col_r, blk_col_nxt;
  logic                       row_act;
  logic                       col_act;
  logic                       col_wrap;
  logic                       row_wrap;
  logic                       line_end;
  logic                       frame_end;

  assign row_act = (geom.bh != '0) &&
                   (row_pos_r >= bbd_pkg::RPOS_W'(geom.ystart)) &&
                   (blk_row_r < bbd_pkg::IDX_W'(bbd_pkg::GRID));
  assign col_act = (geom.bw != '0) &&
                   (col_pos_r >= bbd_pkg::CPOS_W'(geom.xstart)) &&
                   (blk_col_r < bbd_pkg::IDX_W'(bbd_pkg::GRID));
  assign col_wrap  = (cib_r == geom.bw - bbd_pkg::BW_W'(1));
  assign row_wrap  = (rib_r == geom.bh - bbd_pkg::BH_W'(1));
  assign line_end  = (bbd_pkg::COLS_W'(col_pos_r) + bbd_pkg::COLS_W'(1)) >= geom.cols;
  assign frame_end = (bbd_pkg::ROWS_W'(row_pos_r) + bbd_pkg::ROWS_W'(1)) >= geom.rows;

  assign push                = in_fire && row_act && col_act;
  assign push_data.pixel     = in_pixel;
  assign push_data.col_blk   = blk_col_r;
  assign push_data.row_blk   = blk_row_r;
  assign push_data.block_end = row_wrap && col_wrap;
  assign push_data.last      = (blk_col_r == bbd_pkg::IDX_W'(bbd_pkg::GRID - 1)) &&
                               (blk_row_r == bbd_pkg::IDX_W'(bbd_pkg::GRID - 1));

  always_comb begin
    row_pos_nxt = row_pos_r;
    col_pos_nxt = col_pos_r;
    rib_nxt     = rib_r;
    cib_nxt     = cib_r;
    blk_row_nxt = blk_row_r;
    blk_col_nxt = blk_col_r;
    if (restart) begin
      row_pos_nxt = '0;
      col_pos_nxt = '0;
      rib_nxt     = '0;
      cib_nxt     = '0;
      blk_row_nxt = '0;
      blk_col_nxt = '0;
    end else if (in_fire) begin
      if (col_act) begin
        if (col_wrap) begin
          cib_nxt     = '0;
          blk_col_nxt = blk_col_r + bbd_pkg::IDX_W'(1);
        end else begin
          cib_nxt = cib_r + bbd_pkg::BW_W'(1);
        end
      end
      if (line_end) begin
        col_pos_nxt = '0;
        cib_nxt     = '0;
        blk_col_nxt = '0;
        if (row_act) begin
          if (row_wrap) begin
            rib_nxt     = '0;
            blk_row_nxt = blk_row_r + bbd_pkg::IDX_W'(1);
          end else begin
            rib_nxt = rib_r + bbd_pkg::BH_W'(1);
          end
        end
        if (frame_end) begin
          // wrap to a fresh frame
          row_pos_nxt = '0;
          rib_nxt     = '0;
          blk_row_nxt = '0;
        end else begin
          row_pos_nxt = row_pos_r + bbd_pkg::RPOS_W'(1);
        end
      end else begin
        col_pos_nxt = col_pos_r + bbd_pkg::CPOS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r <= '0;
      col_pos_r <= '0;
      rib_r     <= '0;
      cib_r     <= '0;
      blk_row_r <= '0;
      blk_col_r <= '0;
    end else begin
      row_pos_r <= row_pos_nxt;
      col_pos_r <= col_pos_nxt;
      rib_r     <= rib_nxt;
      cib_r     <= cib_nxt;
      blk_row_r <= blk_row_nxt;
      blk_col_r <= blk_col_nxt;
    end
  end

endmodule

@@ rtl/bbd_queue.sv @@
// Short queue of classified pixels between front and back.
`include "binary_block_downsampler_assert.svh"
module bbd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bbd_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output bbd_pkg::q_entry_t head
);

  bbd_pkg::q_entry_t          mem_r [bbd_pkg::Q_DEPTH];
  logic [bbd_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [bbd_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [bbd_pkg::QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == bbd_pkg::QCNT_W'(bbd_pkg::Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + bbd_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + bbd_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + bbd_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - bbd_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `BBD_ASSERT_SAME(a_no_push_full, push, !full, "queue written while full")
  `BBD_ASSERT_SAME(a_no_pop_empty, pop, head_valid, "queue read while empty")
  `BBD_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + 3'd1, "count lost a push")
  `BBD_ASSERT_SAME(a_ptr_track, 1'b1, wr_ptr_r - rd_ptr_r == count_r[bbd_pkg::QPTR_W-1:0], "pointers disagree with count")

endmodule

@@ rtl/bbd_back.sv @@
// Back end: per-column block population, density decision and output register.
module bbd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bbd_pkg::geom_t             geom,
  input  logic                       restart,
  input  logic                       head_valid,
  input  bbd_pkg::q_entry_t          head,
  output logic                       pop,
  output logic                       out_valid,
  output logic                       out_value,
  output logic [bbd_pkg::CELL_W-1:0] out_index,
  output logic                       out_last,
  input  logic                       out_ready
);

  logic [bbd_pkg::SUM_W-1:0]  sums_r [bbd_pkg::GRID];
  logic [bbd_pkg::SUM_W-1:0]  area_r, area_nxt;
  logic [bbd_pkg::SUM_W-1:0]  sum_new;
  logic [bbd_pkg::SUM_W:0]    twice;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_value_r;
  logic [bbd_pkg::CELL_W-1:0] out_index_r;
  logic                       out_last_r;
  logic                       emit;

  assign area_nxt = bbd_pkg::SUM_W'((bbd_pkg::BH_W + bbd_pkg::BW_W)'(geom.bh) *
                                    (bbd_pkg::BH_W + bbd_pkg::BW_W)'(geom.bw));

  // Advance when the output register is free or being emptied this cycle.
  assign pop     = head_valid && (!out_valid_r || out_ready);
  assign emit    = pop && head.block_end;
  assign sum_new = sums_r[head.col_blk] + bbd_pkg::SUM_W'(head.pixel);
  assign twice   = {sum_new, 1'b0};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      area_r      <= '0;
      for (int i = 0; i < bbd_pkg::GRID; i++) begin
        sums_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      area_r      <= area_nxt;
      if (restart) begin
        for (int i = 0; i < bbd_pkg::GRID; i++) begin
          sums_r[i] <= '0;
        end
      end else if (pop) begin
        // drop the count once its block is decided
        sums_r[head.col_blk] <= emit ? '0 : sum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value_r <= (twice >= (bbd_pkg::SUM_W + 1)'(area_r));
      out_index_r <= bbd_pkg::CELL_W'(head.col_blk) * bbd_pkg::CELL_W'(bbd_pkg::GRID) +
                     bbd_pkg::CELL_W'(head.row_blk);
      out_last_r  <= head.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_index = out_index_r;
  assign out_last  = out_last_r;

endmodule

@@ test/tb_binary_block_downsampler.sv @@
// Self-checking testbench for the binary block downsampler: random pixel frames, checked cells.
`timescale 1ns / 1ps

module tb_binary_block_downsampler;

  localparam int QUIET_LIMIT = 1000;  // cycles with no transfer before the run is abandoned
  localparam int SETTLE      = 8;     // cycles allowed for a cell still in the pipe

  typedef struct {
    logic px;
    int   gap;
  } pix_item_t;

  typedef struct {
    logic                       cell_val;
    logic [bbd_pkg::CELL_W-1:0] cell_idx;
    logic                       is_last;
  } cell_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [7:0]                in_tdata = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [15:0]               out_tdata;
  logic                      out_tlast;
  logic                      cfg_we = 1'b0;
  logic [0:0]                cfg_index = bbd_pkg::REG_ROWS;
  logic [bbd_pkg::CFG_W-1:0] cfg_wdata = '0;

  // Shadow geometry and frame walk
  logic [9:0]        rows_reg;
  logic [10:0]       cols_reg;
  logic [9:0]        col_sums [bbd_pkg::GRID];
  logic [8:0]        row_pos;
  logic [9:0]        col_pos;
  logic [4:0]        row_in_blk;
  logic [5:0]        col_in_blk;
  logic [4:0]        blk_row;
  logic [4:0]        blk_col;

  pix_item_t         pixels_pending [$];
  cell_t             cells_due [$];

  logic              holding = 1'b0;
  logic              held_px;
  int                hold_wait;
  int                stall_left = 0;
  int                out_mode = 2;
  bit                out_quiet = 1'b0;
  int                errors = 0;
  int                pixels_sent = 0;
  int                cells_seen = 0;
  int                settings = 0;
  int                quiet_cycles = 0;

  binary_block_downsampler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic void clear_frame();
    for (int b = 0; b < bbd_pkg::GRID; b++) col_sums[b] = '0;
    row_pos    = '0;
    col_pos    = '0;
    row_in_blk = '0;
    col_in_blk = '0;
    blk_row    = '0;
    blk_col    = '0;
  endfunction

  // Walk one pixel through the frame and queue the cell it completes, if any.
  function automatic void advance_pixel(input logic px);
    int    rows, cols, bh, bw, ystart, xstart, bc;
    logic  row_act, col_act;
    cell_t c;
    rows = (rows_reg > bbd_pkg::MAX_ROWS) ? bbd_pkg::MAX_ROWS :
           ((rows_reg == 0) ? 1 : int'(rows_reg));
    cols = (cols_reg > bbd_pkg::MAX_COLS) ? bbd_pkg::MAX_COLS :
           ((cols_reg == 0) ? 1 : int'(cols_reg));
    bh = rows / bbd_pkg::GRID;
    bw = cols / bbd_pkg::GRID;
    ystart = (rows % bbd_pkg::GRID) / 2;
    xstart = (cols % bbd_pkg::GRID) / 2;
    row_act = bh != 0 && row_pos >= ystart && blk_row < bbd_pkg::GRID;
    col_act = bw != 0 && col_pos >= xstart && blk_col < bbd_pkg::GRID;
    if (row_act && col_act) begin
      bc = blk_col;
      col_sums[bc] = col_sums[bc] + px;
      if (row_in_blk == bh - 1 && col_in_blk == bw - 1) begin
        c.cell_val = (2 * col_sums[bc] >= bh * bw);
        c.cell_idx = bbd_pkg::CELL_W'(bc * bbd_pkg::GRID + blk_row);
        c.is_last  = (bc == bbd_pkg::GRID - 1 && blk_row == bbd_pkg::GRID - 1);
        cells_due.push_back(c);
        col_sums[bc] = '0;
      end
    end
    if (col_act) begin
      col_in_blk++;
      if (col_in_blk >= bw) begin
        col_in_blk = '0;
        blk_col++;
      end
    end
    if (col_pos + 1 >= cols) begin
      col_pos    = '0;
      col_in_blk = '0;
      blk_col    = '0;
      if (row_act) begin
        row_in_blk++;
        if (row_in_blk >= bh) begin
          row_in_blk = '0;
          blk_row++;
        end
      end
      if (row_pos + 1 >= rows) clear_frame();
      else row_pos++;
    end else begin
      col_pos++;
    end
  endfunction

  function automatic int draw_idle(input int mode);
    if (mode == 0) return 0;
    if (mode == 1) return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    return $urandom_range(0, 13);
  endfunction

  // Pixel driver
  always @(posedge clk) begin
    pix_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      holding = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_pixel(in_tdata[0]);
        pixels_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (holding) begin
          if (hold_wait == 0) begin
            in_tvalid <= 1'b1;
            in_tdata  <= {7'b0, held_px};
            holding = 1'b0;
          end else begin
            hold_wait--;
            in_tvalid <= 1'b0;
          end
        end else if (pixels_pending.size() != 0) begin
          it = pixels_pending.pop_front();
          if (it.gap == 0) begin
            in_tvalid <= 1'b1;
            in_tdata  <= {7'b0, it.px};
          end else begin
            held_px   = it.px;
            hold_wait = it.gap - 1;
            holding   = 1'b1;
            in_tvalid <= 1'b0;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Cell monitor
  always @(posedge clk) begin
    cell_t want;
    int    n;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else if (out_tvalid && out_tready) begin
      cells_seen++;
      if (cells_seen % 8 == 0) out_mode = out_quiet ? 0 : $urandom_range(0, 2);
      if (cells_due.size() == 0) begin
        errors++;
        $display("%0t: cell with nothing expected: expected none, actual idx %0d val %0d",
                 $time, out_tdata[10:1], out_tdata[0]);
      end else begin
        want = cells_due.pop_front();
        if (out_tdata[0] !== want.cell_val) begin
          errors++;
          $display("%0t: cell_value expected %0d actual %0d", $time, want.cell_val,
                   out_tdata[0]);
        end
        if (out_tdata[10:1] !== want.cell_idx) begin
          errors++;
          $display("%0t: cell_index expected %0d actual %0d", $time, want.cell_idx,
                   out_tdata[10:1]);
        end
        if (out_tlast !== want.is_last) begin
          errors++;
          $display("%0t: last_cell expected %0d actual %0d", $time, want.is_last, out_tlast);
        end
      end
      n = draw_idle(out_mode);
      if (n == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left = n - 1;
      end
    end else if (!out_tready) begin
      if (stall_left == 0) out_tready <= 1'b1;
      else stall_left--;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no transfer for %0d cycles, %0d cells outstanding", $time,
                   QUIET_LIMIT, cells_due.size());
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  // Hold until every pixel is in and every cell is out, then let the pipe settle.
  task automatic drain();
    do @(negedge clk);
    while (pixels_pending.size() != 0 || holding || in_tvalid || cells_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_geometry(input int rv, input int cv);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= bbd_pkg::REG_ROWS;
    cfg_wdata <= bbd_pkg::CFG_W'(rv);
    rows_reg = 10'(rv);
    @(posedge clk);
    cfg_index <= bbd_pkg::REG_COLS;
    cfg_wdata <= bbd_pkg::CFG_W'(cv);
    cols_reg = 11'(cv);
    @(posedge clk);
    cfg_we <= 1'b0;
    clear_frame();
    settings++;
  endtask

  task automatic queue_pattern(input logic [15:0] bits, input int n);
    pix_item_t it;
    @(negedge clk);
    for (int k = 0; k < n; k++) begin
      it.px  = bits[k];
      it.gap = (k % 4 == 3) ? 13 : 0;
      pixels_pending.push_back(it);
    end
  endtask

  // Random pixels; density and idle pattern change every 32 pixels.
  task automatic queue_pixels(input int count, input bit quiet);
    pix_item_t it;
    int        density, gap_mode;
    @(negedge clk);
    for (int k = 0; k < count; k++) begin
      if (k % 32 == 0) begin
        case ($urandom_range(0, 3))
          0:       density = 5;
          1:       density = 50;
          2:       density = 95;
          default: density = $urandom_range(0, 100);
        endcase
        if (quiet) gap_mode = ($urandom_range(0, 7) == 0) ? 1 : 0;
        else gap_mode = $urandom_range(0, 2);
      end
      it.px  = ($urandom_range(0, 99) < density);
      it.gap = draw_idle(gap_mode);
      pixels_pending.push_back(it);
    end
  endtask

  function automatic int pick_side();
    case ($urandom_range(0, 7))
      0, 1, 2: return bbd_pkg::GRID;
      3, 4, 5: return $urandom_range(29, 60);
      6:       return $urandom_range(61, 90);
      default: return $urandom_range(0, 27);
    endcase
  endfunction

  initial begin
    int r, c, count, part;
    rows_reg = 10'(bbd_pkg::RESET_ROWS);
    cols_reg = 11'(bbd_pkg::RESET_COLS);
    clear_frame();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset geometry, zero size, below the grid, margin with odd remainder
    queue_pattern(16'b0000_1100_1010_0101, 12);
    drain();
    set_geometry(0, 0);
    queue_pattern(16'b101, 3);
    drain();
    set_geometry(27, 100);
    queue_pattern(16'b1011, 4);
    drain();
    set_geometry(29, 55);
    queue_pixels(45, 1'b0);
    drain();

    // Oversized rows and columns, then oversized columns with cells of full width
    out_quiet = 1'b1;
    set_geometry(1023, 2047);
    queue_pixels(20, 1'b1);
    drain();
    out_quiet = 1'b0;
    set_geometry(28, 2047);
    queue_pixels(90, 1'b0);
    drain();

    for (int p = 0; p < 5; p++) begin
      r = pick_side();
      c = pick_side();
      set_geometry(r, c);
      count = $urandom_range(30, 60);
      if ($urandom_range(0, 1)) begin
        // pause mid-frame with no register write, then resume the same frame
        part = $urandom_range(1, count - 1);
        queue_pixels(part, 1'b0);
        drain();
        queue_pixels(count - part, 1'b0);
      end else begin
        queue_pixels(count, 1'b0);
      end
      drain();
    end

    if (cells_due.size() != 0) begin
      errors++;
      $display("%0t: %0d expected cells never arrived", $time, cells_due.size());
    end
    $display("Covered %0d pixels and %0d cells over %0d geometry settings,", pixels_sent,
             cells_seen, settings);
    $display("including saturated, zero, below-grid and odd-margin region sizes.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
